[src/uet_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package uet_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int SITE_BITS   = 16;
  localparam int MAX_LIST    = 64;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W   = 16;
  localparam int SITE_W = 16;
  localparam int MAXW_W = 7;

  localparam logic [SITE_W-1:0] SITE_MASK  = SITE_W'((64'd1 << SITE_BITS) - 64'd1);
  localparam logic [MAXW_W-1:0] MAX_LIST_W = MAXW_W'(MAX_LIST);

  typedef enum logic [1:0] {
    ACT_REGISTER  = 2'd0,
    ACT_GET       = 2'd1,
    ACT_FIND      = 2'd2,
    ACT_NEIGHBORS = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
    logic [ID_W-1:0]   route_id;
    logic [MAXW_W-1:0] max_w;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [SITE_W-1:0] end_a;
    logic [SITE_W-1:0] end_b;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [SITE_W-1:0] end_a;
    logic [SITE_W-1:0] end_b;
    logic              found;
    logic              last;
  } res_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[src/uet_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module uet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/uet_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module uet_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [1:0]                     in_action,
  input  wire logic [uet_pkg::SITE_W-1:0]     in_site_a,
  input  wire logic [uet_pkg::SITE_W-1:0]     in_site_b,
  input  wire logic [uet_pkg::ID_W-1:0]       in_route_id,
  input  wire logic [uet_pkg::MAXW_W-1:0]     in_max_wanted,
  output logic                                cmd_valid,
  input  wire logic                           cmd_ready,
  output uet_pkg::cmd_t                       cmd
);

  uet_pkg::cmd_t q_r [2];
  uet_pkg::cmd_t new_cmd;
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          push_ok;
  logic          pop_ok;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_ready && cmd_valid;
  assign cnt_nxt   = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};

  always_comb begin
    new_cmd.action   = uet_pkg::action_t'(in_action);
    new_cmd.site_a   = in_site_a & uet_pkg::SITE_MASK;
    new_cmd.site_b   = in_site_b & uet_pkg::SITE_MASK;
    new_cmd.route_id = in_route_id;
    new_cmd.max_w    = (in_max_wanted > uet_pkg::MAX_LIST_W) ? uet_pkg::MAX_LIST_W
                                                             : in_max_wanted;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[src/uet_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module uet_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire uet_pkg::cmd_t cmd,
  output logic               out_empty,
  input  wire logic          out_pop,
  output uet_pkg::res_t      res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_GET    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam uet_pkg::res_t RES_MISS = '{result_id: '0, end_a: '0, end_b: '0,
                                         found: 1'b0, last: 1'b1};

  state_t                        state_r, state_nxt;
  uet_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [uet_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [uet_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic                          pend_r, pend_nxt;
  logic                          hold_vld_r, hold_vld_nxt;
  logic [uet_pkg::ID_W-1:0]      hold_id_r, hold_id_nxt;
  logic [uet_pkg::MAXW_W-1:0]    n_r, n_nxt;

  logic                          ram_we;
  logic                          ram_re;
  logic [uet_pkg::ADDR_W-1:0]    ram_raddr;
  uet_pkg::entry_t               ram_wdata;
  logic [uet_pkg::ENTRY_W-1:0]   ram_rdata;
  uet_pkg::entry_t               rd;

  uet_pkg::res_t                 oq_r [2];
  logic                          owp_r, orp_r;
  logic [1:0]                    ocnt_r;
  logic                          room;
  logic                          pop_ok;
  logic                          push_en;
  uet_pkg::res_t                 push_res;

  logic                          full_tab;
  logic [uet_pkg::ID_W-1:0]      reg_id;
  logic                          get_hit;
  logic                          idx_more;
  logic                          find_hit;
  logic                          nb_hit;
  logic [uet_pkg::MAXW_W-1:0]    n_inc;

  uet_ram #(
    .WIDTH (uet_pkg::ENTRY_W),
    .DEPTH (uet_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[uet_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = uet_pkg::entry_t'(ram_rdata);
  assign full_tab  = (count_r == uet_pkg::CNT_W'(uet_pkg::TABLE_DEPTH));
  assign reg_id    = (cmd.route_id == '0) ? uet_pkg::ID_W'(count_r + 1'b1) : cmd.route_id;
  assign get_hit   = (cmd.route_id != '0) && (cmd.route_id <= uet_pkg::ID_W'(count_r));
  assign idx_more  = (idx_r < count_r);
  assign find_hit  = ((rd.end_a == cmd_r.site_a) && (rd.end_b == cmd_r.site_b)) ||
                     ((rd.end_a == cmd_r.site_b) && (rd.end_b == cmd_r.site_a));
  assign nb_hit    = (rd.end_a == cmd_r.site_a) || (rd.end_b == cmd_r.site_a);
  assign n_inc     = n_r + 1'b1;
  assign ram_wdata = '{ident: reg_id, end_a: cmd.site_a, end_b: cmd.site_b};

  assign room      = (ocnt_r != 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign pop_ok    = out_pop && !out_empty;
  assign res       = oq_r[orp_r];

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    hold_vld_nxt = hold_vld_r;
    hold_id_nxt  = hold_id_r;
    n_nxt        = n_r;
    cmd_ready    = 1'b0;
    push_en      = 1'b0;
    push_res     = RES_MISS;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx_r[uet_pkg::ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && room) begin
          cmd_ready = 1'b1;
          unique case (cmd.action) inside
            uet_pkg::ACT_REGISTER: begin
              push_en = 1'b1;
              if (!full_tab) begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                push_res  = '{result_id: reg_id, end_a: '0, end_b: '0,
                              found: 1'b1, last: 1'b1};
              end
            end
            uet_pkg::ACT_GET: begin
              if (get_hit) begin
                ram_re    = 1'b1;
                ram_raddr = uet_pkg::ADDR_W'(cmd.route_id - 1'b1);
                state_nxt = ST_GET;
              end else begin
                push_en = 1'b1;
              end
            end
            uet_pkg::ACT_FIND, uet_pkg::ACT_NEIGHBORS: begin
              if ((cmd.action == uet_pkg::ACT_NEIGHBORS) && (cmd.max_w == '0)) begin
                push_en = 1'b1;
              end else begin
                cmd_nxt      = cmd;
                idx_nxt      = '0;
                pend_nxt     = 1'b0;
                hold_vld_nxt = 1'b0;
                n_nxt        = '0;
                state_nxt    = ST_SCAN;
              end
            end
            default: begin
              push_en = 1'b1;
            end
          endcase
        end
      end
      ST_GET: begin
        if (room) begin
          push_en   = 1'b1;
          push_res  = '{result_id: rd.ident, end_a: rd.end_a, end_b: rd.end_b,
                        found: 1'b1, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cmd_r.action == uet_pkg::ACT_FIND) begin
          if (pend_r && find_hit) begin
            if (room) begin
              push_en   = 1'b1;
              push_res  = '{result_id: rd.ident, end_a: '0, end_b: '0,
                            found: 1'b1, last: 1'b1};
              state_nxt = ST_IDLE;
            end
          end else if (idx_more) begin
            ram_re   = 1'b1;
            idx_nxt  = idx_r + 1'b1;
            pend_nxt = 1'b1;
          end else if (room) begin
            push_en   = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (pend_r && nb_hit) begin
            if (!hold_vld_r || room) begin
              push_en      = hold_vld_r;
              push_res     = '{result_id: hold_id_r, end_a: '0, end_b: '0,
                               found: 1'b1, last: 1'b0};
              hold_id_nxt  = rd.ident;
              hold_vld_nxt = 1'b1;
              n_nxt        = n_inc;
              pend_nxt     = 1'b0;
              if ((n_inc != cmd_r.max_w) && idx_more) begin
                ram_re   = 1'b1;
                idx_nxt  = idx_r + 1'b1;
                pend_nxt = 1'b1;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
          end else if (idx_more) begin
            ram_re   = 1'b1;
            idx_nxt  = idx_r + 1'b1;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (room) begin
          push_en = 1'b1;
          if (hold_vld_r) begin
            push_res = '{result_id: hold_id_r, end_a: '0, end_b: '0,
                         found: 1'b1, last: 1'b1};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    hold_id_r <= hold_id_nxt;
    n_r       <= n_nxt;
    if (push_en) begin
      oq_r[owp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      pend_r     <= 1'b0;
      hold_vld_r <= 1'b0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      hold_vld_r <= hold_vld_nxt;
      if (push_en) begin
        owp_r <= ~owp_r;
      end
      if (pop_ok) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, push_en} - {1'b0, pop_ok};
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> room)
    else $error("result written into a full output queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= uet_pkg::CNT_W'(uet_pkg::TABLE_DEPTH))
    else $error("edge count beyond table depth");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index ran past the stored edges");

  a_list_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (cmd_r.action == uet_pkg::ACT_NEIGHBORS))
      |-> (n_r < cmd_r.max_w))
    else $error("neighbor scan continued after reaching its limit");

endmodule
`default_nettype wire

[src/undirected_edge_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Undirected edge table with queue-style channels on both sides.
// An input transaction completes on a rising edge with in_push high and in_full low;
// a two-entry command queue takes up to two commands while earlier work runs.
// Results wait in a two-entry output queue: the oldest one is on the out_ ports
// while out_empty is low and is taken on an edge with out_pop high.
// Register and a miss of get write their result when the back end takes the command;
// a hit of get first reads the table and writes its result from the get state.
// Find and neighbors read one stored edge per cycle through the table's read port
// while no result waits for room; a command never reads past the stored edges, of which there are at most TABLE_DEPTH.
// Find stops at its first match; neighbors stops once it has listed its limit.
// Neighbors holds back each match for one more match so that the final result
// carries last; with no match it gives one result with found low.
// A stalled receiver fills the output queue, which holds a scan at its next result
// without losing its position; the command queue then fills and raises in_full.
// Reset empties both queues and sets the edge count to zero; table contents
// are left as they are and are never read before they are written again.
module undirected_edge_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [1:0]                     in_action,
  input  wire logic [uet_pkg::SITE_W-1:0]     in_site_a,
  input  wire logic [uet_pkg::SITE_W-1:0]     in_site_b,
  input  wire logic [uet_pkg::ID_W-1:0]       in_route_id,
  input  wire logic [uet_pkg::MAXW_W-1:0]     in_max_wanted,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [uet_pkg::ID_W-1:0]            out_result_id,
  output logic [uet_pkg::SITE_W-1:0]          out_end_a,
  output logic [uet_pkg::SITE_W-1:0]          out_end_b,
  output logic                                out_found,
  output logic                                out_last
);

  uet_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;
  uet_pkg::res_t res;

  uet_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_site_a     (in_site_a),
    .in_site_b     (in_site_b),
    .in_route_id   (in_route_id),
    .in_max_wanted (in_max_wanted),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  uet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_result_id = res.result_id;
  assign out_end_a     = res.end_a;
  assign out_end_b     = res.end_b;
  assign out_found     = res.found;
  assign out_last      = res.last;

endmodule
`default_nettype wire

[tb/edge_table_checker.sv]
`timescale 1ns / 1ps
module edge_table_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  input  wire logic                       in_full,
  input  wire logic [1:0]                 in_action,
  input  wire logic [uet_pkg::SITE_W-1:0] in_site_a,
  input  wire logic [uet_pkg::SITE_W-1:0] in_site_b,
  input  wire logic [uet_pkg::ID_W-1:0]   in_route_id,
  input  wire logic [uet_pkg::MAXW_W-1:0] in_max_wanted,
  input  wire logic                       out_empty,
  input  wire logic                       out_pop,
  input  wire logic [uet_pkg::ID_W-1:0]   out_result_id,
  input  wire logic [uet_pkg::SITE_W-1:0] out_end_a,
  input  wire logic [uet_pkg::SITE_W-1:0] out_end_b,
  input  wire logic                       out_found,
  input  wire logic                       out_last,
  output int                              fail_count,
  output int                              outstanding
);

  logic [uet_pkg::SITE_W-1:0] mirror_a  [uet_pkg::TABLE_DEPTH];
  logic [uet_pkg::SITE_W-1:0] mirror_b  [uet_pkg::TABLE_DEPTH];
  logic [uet_pkg::ID_W-1:0]   mirror_id [uet_pkg::TABLE_DEPTH];
  int unsigned                stored_edges;
  uet_pkg::res_t              awaited_results [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    stored_edges = 0;
  end

  function automatic uet_pkg::res_t make_result(input logic [uet_pkg::ID_W-1:0] id,
                                                input logic [uet_pkg::SITE_W-1:0] ea,
                                                input logic [uet_pkg::SITE_W-1:0] eb,
                                                input logic fnd, input logic lst);
    uet_pkg::res_t r;
    r.result_id = id;
    r.end_a     = ea;
    r.end_b     = eb;
    r.found     = fnd;
    r.last      = lst;
    return r;
  endfunction

  task automatic predict_edge_results(input uet_pkg::action_t act,
                                      input logic [uet_pkg::SITE_W-1:0] a,
                                      input logic [uet_pkg::SITE_W-1:0] b,
                                      input logic [uet_pkg::ID_W-1:0] rid,
                                      input logic [uet_pkg::MAXW_W-1:0] want);
    logic [uet_pkg::SITE_W-1:0] sa;
    logic [uet_pkg::SITE_W-1:0] sb;
    logic [uet_pkg::ID_W-1:0]   id;
    int unsigned                limit;
    int unsigned                hits;
    bit                         matched;
    sa      = a & uet_pkg::SITE_MASK;
    sb      = b & uet_pkg::SITE_MASK;
    hits    = 0;
    matched = 1'b0;
    case (act)
      uet_pkg::ACT_REGISTER: begin
        if (stored_edges >= uet_pkg::TABLE_DEPTH) begin
          awaited_results.push_back(make_result('0, '0, '0, 1'b0, 1'b1));
        end else begin
          id = (rid == '0) ? uet_pkg::ID_W'(stored_edges + 1) : rid;
          mirror_a[stored_edges]  = sa;
          mirror_b[stored_edges]  = sb;
          mirror_id[stored_edges] = id;
          stored_edges++;
          awaited_results.push_back(make_result(id, '0, '0, 1'b1, 1'b1));
        end
      end
      uet_pkg::ACT_GET: begin
        if (rid == '0 || rid > stored_edges) begin
          awaited_results.push_back(make_result('0, '0, '0, 1'b0, 1'b1));
        end else begin
          awaited_results.push_back(make_result(mirror_id[rid-1], mirror_a[rid-1],
                                                mirror_b[rid-1], 1'b1, 1'b1));
        end
      end
      uet_pkg::ACT_FIND: begin
        for (int i = 0; i < stored_edges && !matched; i++) begin
          if ((mirror_a[i] == sa && mirror_b[i] == sb) ||
              (mirror_a[i] == sb && mirror_b[i] == sa)) begin
            awaited_results.push_back(make_result(mirror_id[i], '0, '0, 1'b1, 1'b1));
            matched = 1'b1;
          end
        end
        if (!matched) begin
          awaited_results.push_back(make_result('0, '0, '0, 1'b0, 1'b1));
        end
      end
      default: begin
        limit = (want > uet_pkg::MAX_LIST) ? uet_pkg::MAX_LIST : want;
        for (int i = 0; i < stored_edges && hits < limit; i++) begin
          if (mirror_a[i] == sa || mirror_b[i] == sa) begin
            awaited_results.push_back(make_result(mirror_id[i], '0, '0, 1'b1, 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          awaited_results.push_back(make_result('0, '0, '0, 1'b0, 1'b1));
        end else begin
          awaited_results[awaited_results.size()-1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    uet_pkg::res_t head;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_edge_results(uet_pkg::action_t'(in_action), in_site_a, in_site_b,
                             in_route_id, in_max_wanted);
      end
      if (out_pop && !out_empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: result_id %0d, found %0b, last %0b",
                 out_result_id, out_found, out_last);
          fail_count++;
        end else begin
          head = awaited_results.pop_front();
          compare_field("result_id", head.result_id, out_result_id);
          compare_field("end_a", head.end_a, out_end_a);
          compare_field("end_b", head.end_b, out_end_b);
          compare_field("found", 16'(head.found), 16'(out_found));
          compare_field("last", 16'(head.last), 16'(out_last));
        end
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_push       = 1'b0;
  logic [1:0]                 in_action     = 2'b00;
  logic [uet_pkg::SITE_W-1:0] in_site_a     = '0;
  logic [uet_pkg::SITE_W-1:0] in_site_b     = '0;
  logic [uet_pkg::ID_W-1:0]   in_route_id   = '0;
  logic [uet_pkg::MAXW_W-1:0] in_max_wanted = '0;
  logic                       out_pop       = 1'b0;
  logic                       in_full;
  logic                       out_empty;
  logic [uet_pkg::ID_W-1:0]   out_result_id;
  logic [uet_pkg::SITE_W-1:0] out_end_a;
  logic [uet_pkg::SITE_W-1:0] out_end_b;
  logic                       out_found;
  logic                       out_last;
  int                         fail_count;
  int                         outstanding;

  logic [uet_pkg::SITE_W-1:0] sent_a [$];
  logic [uet_pkg::SITE_W-1:0] sent_b [$];
  int                         burst_left = 0;
  int                         pop_left   = 0;

  undirected_edge_table u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_site_a     (in_site_a),
    .in_site_b     (in_site_b),
    .in_route_id   (in_route_id),
    .in_max_wanted (in_max_wanted),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_result_id (out_result_id),
    .out_end_a     (out_end_a),
    .out_end_b     (out_end_b),
    .out_found     (out_found),
    .out_last      (out_last)
  );

  edge_table_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_site_a     (in_site_a),
    .in_site_b     (in_site_b),
    .in_route_id   (in_route_id),
    .in_max_wanted (in_max_wanted),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_result_id (out_result_id),
    .out_end_a     (out_end_a),
    .out_end_b     (out_end_b),
    .out_found     (out_found),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (pop_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_pop  <= 1'b1;
        pop_left <= $urandom_range(10, 40);
      end else begin
        out_pop  <= 1'($urandom_range(0, 1));
        pop_left <= $urandom_range(1, 6);
      end
    end else begin
      pop_left <= pop_left - 1;
    end
  end

  function automatic logic [uet_pkg::SITE_W-1:0] pick_site();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return uet_pkg::SITE_W'($urandom_range(0, 11));
    if (r == 7) return ($urandom_range(0, 1) == 1) ? {uet_pkg::SITE_W{1'b1}} : '0;
    return uet_pkg::SITE_W'($urandom);
  endfunction

  function automatic logic [uet_pkg::MAXW_W-1:0] pick_want();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return uet_pkg::MAXW_W'($urandom_range(0, 8));
    if (r == 5) return '0;
    if (r < 8) return uet_pkg::MAXW_W'($urandom_range(64, 127));
    return uet_pkg::MAXW_W'($urandom_range(0, 127));
  endfunction

  task automatic push_item(input uet_pkg::action_t act,
                           input logic [uet_pkg::SITE_W-1:0] a,
                           input logic [uet_pkg::SITE_W-1:0] b,
                           input logic [uet_pkg::ID_W-1:0] rid,
                           input logic [uet_pkg::MAXW_W-1:0] want);
    int gap;
    in_push       <= 1'b1;
    in_action     <= act;
    in_site_a     <= a;
    in_site_b     <= b;
    in_route_id   <= rid;
    in_max_wanted <= want;
    do @(posedge clk); while (in_full);
    if (act == uet_pkg::ACT_REGISTER && sent_a.size() < uet_pkg::TABLE_DEPTH) begin
      sent_a.push_back(a & uet_pkg::SITE_MASK);
      sent_b.push_back(b & uet_pkg::SITE_MASK);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int                         k;
    int                         sel;
    int                         idx;
    logic [uet_pkg::ID_W-1:0]   rid;
    logic [uet_pkg::SITE_W-1:0] site;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd1, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'd1, 16'd2, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd1, 16'd0, 16'd0, 7'd5);
    push_item(uet_pkg::ACT_REGISTER, 16'd0, 16'd0, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
    push_item(uet_pkg::ACT_REGISTER, 16'd1, 16'd2, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_REGISTER, 16'd2, 16'd1, 16'h5A5A, 7'd0);
    push_item(uet_pkg::ACT_REGISTER, 16'd3, 16'd1, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd1, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd4, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd5, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd6, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'hFFFF, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'd2, 16'd1, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'hFFFF, 16'hFFFF, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'd1, 16'd3, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'd7, 16'd8, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd1, 16'd0, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd1, 16'd0, 16'd0, 7'd1);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd1, 16'd0, 16'd0, 7'd64);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd1, 16'd0, 16'd0, 7'd127);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd9, 16'd0, 16'd0, 7'd10);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'hFFFF, 16'd0, 16'd0, 7'd2);

    for (k = 0; k < 20; k++) begin
      sel = $urandom_range(0, 99);
      idx = (sent_a.size() > 0) ? $urandom_range(0, sent_a.size() - 1) : 0;
      if (sel < 35) begin
        rid = ($urandom_range(0, 1) == 1) ? '0 : uet_pkg::ID_W'($urandom);
        push_item(uet_pkg::ACT_REGISTER, pick_site(), pick_site(), rid,
                  uet_pkg::MAXW_W'($urandom));
      end else if (sel < 55) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) rid = '0;
        else if (sel < 3) rid = uet_pkg::ID_W'($urandom);
        else rid = uet_pkg::ID_W'($urandom_range(1, sent_a.size() + 2));
        push_item(uet_pkg::ACT_GET, uet_pkg::SITE_W'($urandom), uet_pkg::SITE_W'($urandom),
                  rid, uet_pkg::MAXW_W'($urandom));
      end else if (sel < 75) begin
        if (sent_a.size() > 0 && $urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 1) == 1) begin
            push_item(uet_pkg::ACT_FIND, sent_a[idx], sent_b[idx],
                      uet_pkg::ID_W'($urandom), uet_pkg::MAXW_W'($urandom));
          end else begin
            push_item(uet_pkg::ACT_FIND, sent_b[idx], sent_a[idx],
                      uet_pkg::ID_W'($urandom), uet_pkg::MAXW_W'($urandom));
          end
        end else begin
          push_item(uet_pkg::ACT_FIND, pick_site(), pick_site(),
                    uet_pkg::ID_W'($urandom), uet_pkg::MAXW_W'($urandom));
        end
      end else begin
        if (sent_a.size() > 0 && $urandom_range(0, 9) < 7) begin
          site = ($urandom_range(0, 1) == 1) ? sent_a[idx] : sent_b[idx];
        end else begin
          site = pick_site();
        end
        push_item(uet_pkg::ACT_NEIGHBORS, site, uet_pkg::SITE_W'($urandom),
                  uet_pkg::ID_W'($urandom), pick_want());
      end
    end

    while (sent_a.size() < uet_pkg::TABLE_DEPTH) begin
      rid = ($urandom_range(0, 3) == 0) ? uet_pkg::ID_W'($urandom) : '0;
      push_item(uet_pkg::ACT_REGISTER, pick_site(), pick_site(), rid, '0);
    end

    push_item(uet_pkg::ACT_REGISTER, 16'd4, 16'd5, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_REGISTER, 16'hFFFF, 16'd0, 16'h1234, 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, uet_pkg::ID_W'(uet_pkg::TABLE_DEPTH), 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, uet_pkg::ID_W'(uet_pkg::TABLE_DEPTH + 1), 7'd0);
    push_item(uet_pkg::ACT_GET, 16'd0, 16'd0, 16'd1, 7'd0);
    push_item(uet_pkg::ACT_FIND, sent_b[uet_pkg::TABLE_DEPTH-1], sent_a[uet_pkg::TABLE_DEPTH-1],
              16'd0, 7'd0);
    push_item(uet_pkg::ACT_FIND, 16'h1234, 16'h4321, 16'd0, 7'd0);
    push_item(uet_pkg::ACT_NEIGHBORS, sent_a[uet_pkg::TABLE_DEPTH-1], 16'd0, 16'd0, 7'd127);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'd3, 16'd0, 16'd0, 7'd64);
    push_item(uet_pkg::ACT_NEIGHBORS, 16'h7777, 16'd0, 16'd0, 7'd64);

    in_push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (uet_pkg::TABLE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/uet_pkg.sv
src/uet_ram.sv
src/uet_front.sv
src/uet_back.sv
src/undirected_edge_table.sv
tb/edge_table_checker.sv
tb/tb.sv
